// File: rtl/core/osf_pkg.sv
// ----------------------------------------------------------------------------
// osf_pkg
// shared types and constants of the overlapping sample framer
// ----------------------------------------------------------------------------
package osf_pkg;

  localparam int CFG_BITS     = 10;
  localparam int CFG_IDX_BITS = 1;
  localparam int MAX_FRAME    = 512;
  localparam int OFF_BITS     = 9;
  localparam int PCM_BITS     = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_LENGTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HOP    = 1'b1;

  localparam logic [CFG_BITS-1:0] LENGTH_RESET = 10'd400;
  localparam logic [CFG_BITS-1:0] HOP_RESET    = 10'd160;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_READ,
    CMD_DROP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    logic      last;
  } cmd_ctrl_t;

endpackage

// File: rtl/core/osf_front.sv
// ----------------------------------------------------------------------------
// osf_front
// request classifier: frame bookkeeping, ring addressing and config registers
// ----------------------------------------------------------------------------
module osf_front import osf_pkg::*; #(
  parameter int RING_DEPTH  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]         cfg_index_i,
  input  logic [CFG_BITS-1:0]             cfg_data_i,
  input  logic                            accept_i,
  input  logic                            mode_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in_i,
  output cmd_ctrl_t                       cmd_ctrl_o,
  output logic [$clog2(RING_DEPTH)-1:0]   cmd_addr_o,
  output logic [((SAMPLE_BITS < PCM_BITS) ? SAMPLE_BITS : PCM_BITS)-1:0] cmd_data_o
);

  localparam int PTR_W   = $clog2(RING_DEPTH);
  localparam int FILL_W  = $clog2(RING_DEPTH + 1);
  localparam int CMP_W   = (FILL_W > CFG_BITS) ? FILL_W : CFG_BITS;
  localparam int SUM_W   = CMP_W + 1;
  localparam int STORE_W = (SAMPLE_BITS < PCM_BITS) ? SAMPLE_BITS : PCM_BITS;
  localparam int LEN_MAX = (MAX_FRAME < RING_DEPTH) ? MAX_FRAME : RING_DEPTH;

  logic [CFG_BITS-1:0] frame_length_q, frame_hop_q;
  logic [PTR_W-1:0]    start_q, start_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [OFF_BITS-1:0] off_q, off_d;
  logic [OFF_BITS-1:0] skip_q, skip_d;

  logic [CMP_W-1:0] len_ext, hop_ext, len_eff, hop_eff, fill_ext, off_ext;
  logic [CMP_W-1:0] addend, advance;
  logic [PTR_W-1:0] addr_wrap, start_adv;
  logic             frame_last;

  function automatic logic [PTR_W-1:0] ring_wrap(logic [PTR_W-1:0] base,
                                                 logic [CMP_W-1:0] step);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(step);
    if (sum >= SUM_W'(RING_DEPTH)) begin
      sum = sum - SUM_W'(RING_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // effective length and hop
  always_comb begin
    len_ext = CMP_W'(frame_length_q);
    hop_ext = CMP_W'(frame_hop_q);
    if (len_ext == '0) begin
      len_eff = CMP_W'(1);
    end else if (len_ext > CMP_W'(LEN_MAX)) begin
      len_eff = CMP_W'(LEN_MAX);
    end else begin
      len_eff = len_ext;
    end
    if (hop_ext == '0) begin
      hop_eff = CMP_W'(1);
    end else if (hop_ext > CMP_W'(MAX_FRAME)) begin
      hop_eff = CMP_W'(MAX_FRAME);
    end else begin
      hop_eff = hop_ext;
    end
  end

  assign fill_ext   = CMP_W'(fill_q);
  assign off_ext    = CMP_W'(off_q);
  assign addend     = (mode_i == MODE_READ) ? off_ext : fill_ext;
  assign addr_wrap  = ring_wrap(start_q, addend);
  assign advance    = (fill_ext >= hop_eff) ? hop_eff : fill_ext;
  assign start_adv  = ring_wrap(start_q, advance);
  assign frame_last = (off_ext + CMP_W'(1)) >= len_eff;

  assign cmd_addr_o = addr_wrap;
  assign cmd_data_o = sample_in_i[STORE_W-1:0];

  always_comb begin
    start_d         = start_q;
    fill_d          = fill_q;
    off_d           = off_q;
    skip_d          = skip_q;
    cmd_ctrl_o.kind = CMD_NONE;
    cmd_ctrl_o.last = 1'b0;
    if (accept_i) begin
      if (mode_i == MODE_PUSH) begin
        if (skip_q != '0) begin
          skip_d = skip_q - OFF_BITS'(1);
        end else if (fill_ext == CMP_W'(RING_DEPTH)) begin
          cmd_ctrl_o.kind = CMD_DROP;
        end else begin
          cmd_ctrl_o.kind = CMD_WRITE;
          fill_d          = fill_q + FILL_W'(1);
        end
      end else if (fill_ext >= len_eff) begin
        cmd_ctrl_o.kind = CMD_READ;
        cmd_ctrl_o.last = frame_last;
        if (frame_last) begin
          off_d   = '0;
          start_d = start_adv;
          if (fill_ext >= hop_eff) begin
            fill_d = FILL_W'(fill_ext - hop_eff);
          end else begin
            skip_d = OFF_BITS'(hop_eff - fill_ext);
            fill_d = '0;
          end
        end else begin
          off_d = off_q + OFF_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q <= LENGTH_RESET;
      frame_hop_q    <= HOP_RESET;
      start_q        <= '0;
      fill_q         <= '0;
      off_q          <= '0;
      skip_q         <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_LENGTH: frame_length_q <= cfg_data_i;
        CFG_FRAME_HOP:    frame_hop_q    <= cfg_data_i;
        default: ;
      endcase
      off_q <= '0;
    end else begin
      start_q <= start_d;
      fill_q  <= fill_d;
      off_q   <= off_d;
      skip_q  <= skip_d;
    end
  end

endmodule

// File: rtl/core/osf_queue.sv
// ----------------------------------------------------------------------------
// osf_queue
// short command queue between the classifier and the ring access stage
// ----------------------------------------------------------------------------
module osf_queue import osf_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/osf_back.sv
// ----------------------------------------------------------------------------
// osf_back
// ring memory access stage and result register
// ----------------------------------------------------------------------------
module osf_back import osf_pkg::*; #(
  parameter int RING_DEPTH  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_empty_i,
  input  cmd_ctrl_t                       q_ctrl_i,
  input  logic [$clog2(RING_DEPTH)-1:0]   q_addr_i,
  input  logic [((SAMPLE_BITS < PCM_BITS) ? SAMPLE_BITS : PCM_BITS)-1:0] q_data_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]   sample_out_o,
  output logic                            last_of_frame_o,
  output logic                            read_valid_o,
  output logic                            push_dropped_o
);

  localparam int STORE_W = (SAMPLE_BITS < PCM_BITS) ? SAMPLE_BITS : PCM_BITS;

  logic [STORE_W-1:0] ring_q [RING_DEPTH];
  logic [STORE_W-1:0] rdata_q;

  logic             s1_valid_q;
  cmd_ctrl_t        s1_ctrl_q;
  logic             out_valid_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic             last_q, rvalid_q, dropped_q;
  logic             advance, s1_move, pop;

  assign advance = !out_valid_q || !out_stall_i;
  assign s1_move = s1_valid_q && advance;
  assign pop     = !q_empty_i && (!s1_valid_q || advance);
  assign q_pop_o = pop;

  // single port ring, registered read
  always_ff @(posedge clk_i) begin
    if (pop && q_ctrl_i.kind == CMD_WRITE) begin
      ring_q[q_addr_i] <= q_data_i;
    end
    if (pop && q_ctrl_i.kind == CMD_READ) begin
      rdata_q <= ring_q[q_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_ctrl_q <= q_ctrl_i;
    end
    if (s1_move) begin
      case (s1_ctrl_q.kind)
        CMD_READ: begin
          sample_q  <= SAMPLE_BITS'(rdata_q);
          last_q    <= s1_ctrl_q.last;
          rvalid_q  <= 1'b1;
          dropped_q <= 1'b0;
        end
        CMD_DROP: begin
          sample_q  <= '0;
          last_q    <= 1'b0;
          rvalid_q  <= 1'b0;
          dropped_q <= 1'b1;
        end
        default: begin
          sample_q  <= '0;
          last_q    <= 1'b0;
          rvalid_q  <= 1'b0;
          dropped_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= pop || (s1_valid_q && !advance);
      out_valid_q <= s1_move || (out_valid_q && out_stall_i);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = sample_q;
  assign last_of_frame_o = last_q;
  assign read_valid_o    = rvalid_q;
  assign push_dropped_o  = dropped_q;

endmodule

// File: rtl/core/overlapping_sample_framer_unit.sv
// ----------------------------------------------------------------------------
// overlapping_sample_framer_unit
// cuts a sample stream into overlapping frames held in a ring buffer
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o   | mode_i, sample_in_i
//  out     | output    | out_valid_o / out_stall_i | sample_out_o, last_of_frame_o,
//          |           |                        | read_valid_o, push_dropped_o
//  cfg     | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
//  one request per cycle while in_stall_o is low; a result passes through the
//  queue slot, the registered ring read and the result register
//  reset clears pointers, counts and handshake state; the ring is not cleared
//  a two-entry queue takes requests until it is full while the output is stalled
// ----------------------------------------------------------------------------
module overlapping_sample_framer_unit import osf_pkg::*; #(
  parameter int RING_DEPTH  = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [CFG_BITS-1:0]           cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          last_of_frame_o,
  output logic                          read_valid_o,
  output logic                          push_dropped_o
);

  localparam int PTR_W   = $clog2(RING_DEPTH);
  localparam int STORE_W = (SAMPLE_BITS < PCM_BITS) ? SAMPLE_BITS : PCM_BITS;
  localparam int CTRL_W  = $bits(cmd_ctrl_t);
  localparam int QW      = CTRL_W + PTR_W + STORE_W;

  logic               accept;
  cmd_ctrl_t          f_ctrl, b_ctrl;
  logic [PTR_W-1:0]   f_addr, b_addr;
  logic [STORE_W-1:0] f_data, b_data;
  logic [QW-1:0]      q_wdata, q_rdata;
  logic               q_full, q_empty, q_pop;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  osf_front #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .sample_in_i (sample_in_i),
    .cmd_ctrl_o  (f_ctrl),
    .cmd_addr_o  (f_addr),
    .cmd_data_o  (f_data)
  );

  assign q_wdata = {f_ctrl, f_addr, f_data};

  osf_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign b_ctrl = cmd_ctrl_t'(q_rdata[QW-1 -: CTRL_W]);
  assign b_addr = q_rdata[STORE_W +: PTR_W];
  assign b_data = q_rdata[STORE_W-1:0];

  osf_back #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_ctrl_i        (b_ctrl),
    .q_addr_i        (b_addr),
    .q_data_i        (b_data),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_out_o    (sample_out_o),
    .last_of_frame_o (last_of_frame_o),
    .read_valid_o    (read_valid_o),
    .push_dropped_o  (push_dropped_o)
  );

  a_stall_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !q_empty)
    else $error("input stalled with an empty queue");

  a_last_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_frame_o) |-> read_valid_o)
    else $error("frame end flagged without a valid read");

  a_read_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && read_valid_o) |-> !push_dropped_o)
    else $error("result is both a read and a dropped push");

  a_zero_sample_off_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !read_valid_o) |-> (sample_out_o == '0))
    else $error("nonzero sample on a result that is not a read");

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks overlapping_sample_framer_unit against a cycle-free frame predictor
//
// push and read requests go in through the input channel. Each taken request
// updates a local copy of the ring, pointers and registers, which queues the
// one result it should produce. Every result taken from the output channel is
// compared field by field with the oldest queued one. Directed requests cover
// the sample extremes, empty reads, frame release, register restarts and gap
// samples. Random phases then fill the ring to the top, sweep the register
// extremes and hold the output off long enough to back up the input, and
// end with a stretch that has no idling on either side.
// ----------------------------------------------------------------------------
module testbench;
  import osf_pkg::*;

  localparam int RING_DEPTH  = 1024;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic signed [PCM_BITS-1:0] pcm;
    logic                       frame_end;
    logic                       hit;
    logic                       dropped;
  } frame_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_IDX_BITS-1:0]    cfg_index_i;
  logic [CFG_BITS-1:0]        cfg_data_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic                       mode_i;
  logic signed [PCM_BITS-1:0] sample_in_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [PCM_BITS-1:0] sample_out_o;
  logic                       last_of_frame_o;
  logic                       read_valid_o;
  logic                       push_dropped_o;

  // predictor state
  logic signed [PCM_BITS-1:0] pcm_ring [0:RING_DEPTH-1];
  logic [9:0]                 start_ptr    = '0;
  logic [10:0]                stored_count = '0;
  logic [OFF_BITS-1:0]        frame_pos    = '0;
  logic [OFF_BITS-1:0]        gap_left     = '0;
  logic [CFG_BITS-1:0]        length_reg   = LENGTH_RESET;
  logic [CFG_BITS-1:0]        hop_reg      = HOP_RESET;

  frame_result_t due_results [$];
  frame_result_t want;

  logic quiet        = 1'b0;
  logic hold_off_req = 1'b0;
  int   error_count     = 0;
  int   results_checked = 0;
  int   requests_sent   = 0;
  int   frames_closed   = 0;
  int   empty_reads     = 0;
  int   full_drops      = 0;
  int   gap_skips       = 0;
  int   cycle_count     = 0;

  overlapping_sample_framer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .sample_in_i    (sample_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_out_o   (sample_out_o),
    .last_of_frame_o(last_of_frame_o),
    .read_valid_o   (read_valid_o),
    .push_dropped_o (push_dropped_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  function automatic frame_result_t next_frame_result(logic mode,
                                                      logic signed [PCM_BITS-1:0] pcm);
    frame_result_t r;
    int            len;
    int            hop;
    logic [9:0]    pos;
    r   = '0;
    len = (length_reg == 0) ? 1 : ((length_reg > MAX_FRAME) ? MAX_FRAME : int'(length_reg));
    hop = (hop_reg == 0) ? 1 : ((hop_reg > MAX_FRAME) ? MAX_FRAME : int'(hop_reg));
    if (mode == MODE_PUSH) begin
      if (gap_left != 0) begin
        gap_left--;
        gap_skips++;
      end else if (stored_count == RING_DEPTH) begin
        r.dropped = 1'b1;
        full_drops++;
      end else begin
        pos = start_ptr + stored_count[9:0];
        pcm_ring[pos] = pcm;
        stored_count++;
      end
    end else if (int'(stored_count) >= len) begin
      pos = start_ptr + 10'(frame_pos);
      r.pcm = pcm_ring[pos];
      r.hit = 1'b1;
      if (int'(frame_pos) + 1 >= len) begin
        r.frame_end = 1'b1;
        frame_pos   = '0;
        frames_closed++;
        if (int'(stored_count) >= hop) begin
          start_ptr    = start_ptr + 10'(hop);
          stored_count = stored_count - 11'(hop);
        end else begin
          // not a whole hop stored: release everything and skip the rest
          start_ptr    = start_ptr + stored_count[9:0];
          gap_left     = OFF_BITS'(hop - int'(stored_count));
          stored_count = '0;
        end
      end else begin
        frame_pos++;
      end
    end else begin
      empty_reads++;
    end
    return r;
  endfunction

  // receiver side: random stall bursts, or one long hold when requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i  = 1'b0;
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic signed [PCM_BITS-1:0] exp_v,
                             logic signed [PCM_BITS-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (due_results.size() == 0) begin
        $error("result arrived with no request pending");
        error_count++;
      end else begin
        want = due_results.pop_front();
        check_field("sample_out", want.pcm, sample_out_o);
        check_field("last_of_frame", PCM_BITS'(want.frame_end), PCM_BITS'(last_of_frame_o));
        check_field("read_valid", PCM_BITS'(want.hit), PCM_BITS'(read_valid_o));
        check_field("push_dropped", PCM_BITS'(want.dropped), PCM_BITS'(push_dropped_o));
      end
    end
  end

  task automatic send_request(logic mode, logic signed [PCM_BITS-1:0] pcm);
    logic          taken;
    frame_result_t exp_r;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    mode_i      = mode;
    sample_in_i = pcm;
    taken       = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
      @(negedge clk_i);
    end
    exp_r       = next_frame_result(mode, pcm);
    due_results = {due_results, exp_r};
    requests_sent++;
    in_valid_i = 1'b0;
  endtask

  task automatic send_random(int read_pct);
    send_request(($urandom_range(0, 99) < read_pct) ? MODE_READ : MODE_PUSH,
                 PCM_BITS'($urandom));
  endtask

  task automatic drain();
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
    drain();
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_FRAME_LENGTH) begin
      length_reg = value;
    end else begin
      hop_reg = value;
    end
    frame_pos = '0;
  endtask

  task automatic run_phase(logic [CFG_BITS-1:0] len, logic [CFG_BITS-1:0] hop,
                           int count, int read_pct);
    write_register(CFG_FRAME_LENGTH, len);
    write_register(CFG_FRAME_HOP, hop);
    repeat (count) send_random(read_pct);
  endtask

  task automatic test_directed();
    // empty read at reset settings
    send_request(MODE_READ, 16'sh1234);
    write_register(CFG_FRAME_LENGTH, 10'd3);
    write_register(CFG_FRAME_HOP, 10'd2);
    send_request(MODE_PUSH, 16'sh7fff);
    send_request(MODE_PUSH, -16'sd32768);
    send_request(MODE_READ, '0);
    send_request(MODE_PUSH, -16'sd1);
    send_request(MODE_PUSH, 16'sh0000);
    repeat (3) send_request(MODE_READ, 16'sh7fff);
    // overlapping second frame
    send_request(MODE_PUSH, 16'sh5555);
    repeat (3) send_request(MODE_READ, -16'sd1);
    // hop longer than frame, with a restart mid-frame
    write_register(CFG_FRAME_HOP, 10'd5);
    send_request(MODE_PUSH, -16'sd21846);
    send_request(MODE_PUSH, 16'sh0001);
    send_request(MODE_READ, '0);
    write_register(CFG_FRAME_LENGTH, 10'd3);
    repeat (3) send_request(MODE_READ, '0);
    send_request(MODE_PUSH, 16'sh1111);
    send_request(MODE_PUSH, 16'sh2222);
    send_request(MODE_PUSH, 16'sh3333);
  endtask

  task automatic test_ring_full();
    write_register(CFG_FRAME_LENGTH, 10'd5);
    write_register(CFG_FRAME_HOP, 10'd3);
    hold_off_req = 1'b1;
    while (stored_count != RING_DEPTH) send_random(0);
    repeat (8) send_random(0);
    repeat (40) send_random(80);
    // sender waits for every result before going on
    drain();
  endtask

  task automatic test_register_sweep();
    run_phase(10'd512, 10'd1, 40, 60);
    run_phase(10'd1023, 10'd1023, 40, 50);
    run_phase(10'd0, 10'd0, 40, 50);
    run_phase(10'd1, 10'd1023, 40, 50);
    run_phase(10'd2, 10'd513, 40, 45);
    run_phase(10'd7, 10'd13, 40, 50);
    run_phase(10'd16, 10'd16, 40, 50);
  endtask

  task automatic test_streaming();
    quiet = 1'b1;
    run_phase(10'd10, 10'd4, 80, 50);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_FRAME_LENGTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    mode_i      = MODE_PUSH;
    sample_in_i = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_ring_full();
    test_register_sweep();
    test_streaming();
    drain();
    repeat (8) @(negedge clk_i);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      error_count++;
    end
    $display("%0d requests, %0d results compared, %0d frames closed, %0d empty reads",
             requests_sent, results_checked, frames_closed, empty_reads);
    $display("%0d pushes dropped on a full ring, %0d gap samples skipped, %0d mismatches",
             full_drops, gap_skips, error_count);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/osf_pkg.sv
rtl/core/osf_front.sv
rtl/core/osf_queue.sv
rtl/core/osf_back.sv
rtl/core/overlapping_sample_framer_unit.sv
verif/testbench.sv
